>>> rtl/core/whps_pkg.sv
// whps_pkg: shared types and constants for the wheel point to hue/saturation block
// arctangent table, gain compensation, register indexes and pipeline control struct
// no dependencies
package whps_pkg;

	localparam int ATAN_ENTRIES = 24;
	localparam int FRAC_BITS    = 8;
	localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
	localparam logic [15:0] HALF_TURN    = 16'd32768;
	localparam logic [8:0]  HUE_SCALE    = 9'd360;
	localparam logic [7:0]  SAT_MAX      = 8'd255;
	localparam logic [12:0] CENTER_RESET = 13'd75;
	localparam logic [11:0] RADIUS_RESET = 12'd75;

	localparam logic [15:0] ATAN_TURNS [ATAN_ENTRIES] = '{
		16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163, 16'd81,
		16'd41, 16'd20, 16'd10, 16'd5, 16'd3, 16'd1, 16'd1, 16'd0,
		16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
	};

	typedef enum logic [1:0] {
		REG_CENTER_X = 2'd0,
		REG_CENTER_Y = 2'd1,
		REG_RADIUS   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic valid;
		logic center;
	} ctl_t;

endpackage

>>> rtl/core/wheel_point_to_hue_saturation.sv
// wheel_point_to_hue_saturation: top level, pointer position to wheel hue and saturation
// depends on whps_pkg, whps_cordic_stage, whps_div_stage
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | pointer_x, pointer_y
//  m_*     | out | m_tvalid/m_tready  | hue, saturation
//  cfg_*   | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one item per cycle while the output queue is not full
// stages in order: front end, CORDIC chain, multiply, numerator, eight divider steps
// reset clears the valid bits and loads the register defaults; cfg_ready is always high
// a two-entry output queue decouples m_tready; the pipeline halts only when it is full
module wheel_point_to_hue_saturation #(
	parameter int CORDIC_STAGES = 16,
	parameter int COORD_BITS    = 14
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// pointer_x, pointer_y, zero pad
	input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// hue, saturation, zero pad
	output logic [23:0]                            m_tdata,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [1:0]                             cfg_index,
	input  logic [12:0]                            cfg_data
);

	localparam int D  = (COORD_BITS > 14 ? COORD_BITS : 14) + 1;
	localparam int W  = D + whps_pkg::FRAC_BITS + 3;
	localparam int MW = W - 1;
	localparam int RW = MW + 8;

	logic [12:0] cx_q, cy_q;
	logic [11:0] rad_q;
	logic        en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q  <= whps_pkg::CENTER_RESET;
			cy_q  <= whps_pkg::CENTER_RESET;
			rad_q <= whps_pkg::RADIUS_RESET;
		end else if (cfg_valid) begin
			case (whps_pkg::reg_idx_t'(cfg_index))
				whps_pkg::REG_CENTER_X: cx_q <= cfg_data;
				whps_pkg::REG_CENTER_Y: cy_q <= cfg_data;
				whps_pkg::REG_RADIUS:   rad_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// front end: offsets and half-turn prerotation
	logic signed [COORD_BITS-1:0] px, py;
	logic signed [D-1:0] dx, dy;
	logic signed [W-1:0] xi, yi;
	logic signed [W-1:0] x_s1, y_s1;
	logic [15:0]         z_s1;
	whps_pkg::ctl_t      ctl_s1;

	always_comb begin
		px = s_tdata[COORD_BITS-1:0];
		py = s_tdata[2*COORD_BITS-1:COORD_BITS];
		dx = D'(px) - D'($signed({1'b0, cx_q}));
		dy = D'($signed({1'b0, cy_q})) - D'(py);
		xi = W'(dy) <<< whps_pkg::FRAC_BITS;
		yi = W'(dx) <<< whps_pkg::FRAC_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.valid  <= s_tvalid;
			ctl_s1.center <= (dx == '0) && (dy == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (xi[W-1]) begin
				x_s1 <= -xi;
				y_s1 <= -yi;
				z_s1 <= whps_pkg::HALF_TURN;
			end else begin
				x_s1 <= xi;
				y_s1 <= yi;
				z_s1 <= '0;
			end
		end
	end

	// cordic chain
	logic signed [W-1:0] cx [CORDIC_STAGES+1];
	logic signed [W-1:0] cy [CORDIC_STAGES+1];
	logic [15:0]         cz [CORDIC_STAGES+1];
	whps_pkg::ctl_t      cc [CORDIC_STAGES+1];

	assign cx[0] = x_s1;
	assign cy[0] = y_s1;
	assign cz[0] = z_s1;
	assign cc[0] = ctl_s1;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		whps_cordic_stage #(.W(W), .IDX(i)) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.ctl_in  (cc[i]),
			.x_in    (cx[i]),
			.y_in    (cy[i]),
			.z_in    (cz[i]),
			.ctl_out (cc[i+1]),
			.x_out   (cx[i+1]),
			.y_out   (cy[i+1]),
			.z_out   (cz[i+1])
		);
	end

	// gain compensation and hue scaling
	logic [W+15:0]  mag_prod;
	logic [24:0]    hue_prod;
	logic [MW-1:0]  mag_s2;
	logic [8:0]     hue_s2;
	whps_pkg::ctl_t ctl_s2;

	always_comb begin
		mag_prod = (W+16)'(cx[CORDIC_STAGES][W-2:0]) * (W+16)'(whps_pkg::INV_GAIN_Q16);
		hue_prod = 25'(cz[CORDIC_STAGES]) * 25'(whps_pkg::HUE_SCALE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= cc[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2 <= mag_prod[W+14:16];
			hue_s2 <= cc[CORDIC_STAGES].center ? 9'd0 : hue_prod[24:16];
		end
	end

	// numerator and saturation check
	logic [19:0]    divisor;
	logic [RW-1:0]  num;
	logic [RW-1:0]  rem_s3;
	logic           sat_s3;
	logic [8:0]     hue_s3;
	whps_pkg::ctl_t ctl_s3;

	always_comb begin
		divisor = {(rad_q == '0) ? 12'd1 : rad_q, 8'd0};
		num     = (RW'(mag_s2) << 8) - RW'(mag_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s3 <= num;
			sat_s3 <= num >= (RW'(divisor) << 8);
			hue_s3 <= hue_s2;
		end
	end

	// divider chain
	logic [RW-1:0]  dr [9];
	logic [7:0]     dq [9];
	logic           ds [9];
	logic [8:0]     dh [9];
	whps_pkg::ctl_t dc [9];

	assign dr[0] = rem_s3;
	assign dq[0] = '0;
	assign ds[0] = sat_s3;
	assign dh[0] = hue_s3;
	assign dc[0] = ctl_s3;

	for (genvar j = 0; j < 8; j++) begin : g_div
		whps_div_stage #(.RW(RW), .K(7 - j)) u_div (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.divisor (divisor),
			.ctl_in  (dc[j]),
			.rem_in  (dr[j]),
			.q_in    (dq[j]),
			.sat_in  (ds[j]),
			.hue_in  (dh[j]),
			.ctl_out (dc[j+1]),
			.rem_out (dr[j+1]),
			.q_out   (dq[j+1]),
			.sat_out (ds[j+1]),
			.hue_out (dh[j+1])
		);
	end

	// output queue
	logic [16:0] q_mem_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        push, pop;
	logic [7:0]  sat_res;

	assign en       = (cnt_q != 2'd2);
	assign s_tready = en;
	assign sat_res  = ds[8] ? whps_pkg::SAT_MAX : dq[8];
	assign push     = en && dc[8].valid;
	assign pop      = m_tvalid && m_tready;

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= {sat_res, dh[8]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = {7'd0, q_mem_q[rd_ptr_q]};

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("output queue count overflow");
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[8:0] < whps_pkg::HUE_SCALE)) else $error("hue out of range");
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !m_tready) |=> (cnt_q == 2'd2)) else $error("full queue lost an item");
	a_push_space: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != 2'd2)) else $error("push into full queue");

endmodule

>>> rtl/core/whps_cordic_stage.sv
// whps_cordic_stage: one registered vectoring microrotation
// depends on whps_pkg
module whps_cordic_stage #(
	parameter int W   = 26,
	parameter int IDX = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  whps_pkg::ctl_t        ctl_in,
	input  logic signed [W-1:0]   x_in,
	input  logic signed [W-1:0]   y_in,
	input  logic [15:0]           z_in,
	output whps_pkg::ctl_t        ctl_out,
	output logic signed [W-1:0]   x_out,
	output logic signed [W-1:0]   y_out,
	output logic [15:0]           z_out
);

	logic signed [W-1:0] xs, ys, x_nx, y_nx;
	logic [15:0] z_nx;

	always_comb begin
		xs = x_in >>> IDX;
		ys = y_in >>> IDX;
		if (!y_in[W-1]) begin
			x_nx = x_in + ys;
			y_nx = y_in - xs;
			z_nx = z_in + whps_pkg::ATAN_TURNS[IDX];
		end else begin
			x_nx = x_in - ys;
			y_nx = y_in + xs;
			z_nx = z_in - whps_pkg::ATAN_TURNS[IDX];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else if (en) begin
			ctl_out <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_out <= x_nx;
			y_out <= y_nx;
			z_out <= z_nx;
		end
	end

endmodule

>>> rtl/core/whps_div_stage.sv
// whps_div_stage: one registered restoring division step for the saturation quotient
// depends on whps_pkg
module whps_div_stage #(
	parameter int RW = 33,
	parameter int K  = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [19:0]      divisor,
	input  whps_pkg::ctl_t   ctl_in,
	input  logic [RW-1:0]    rem_in,
	input  logic [7:0]       q_in,
	input  logic             sat_in,
	input  logic [8:0]       hue_in,
	output whps_pkg::ctl_t   ctl_out,
	output logic [RW-1:0]    rem_out,
	output logic [7:0]       q_out,
	output logic             sat_out,
	output logic [8:0]       hue_out
);

	logic [RW-1:0] trial;
	logic          take;

	always_comb begin
		trial = RW'(divisor) << K;
		take  = rem_in >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else if (en) begin
			ctl_out <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out <= take ? rem_in - trial : rem_in;
			q_out   <= q_in | (take ? 8'(1 << K) : 8'd0);
			sat_out <= sat_in;
			hue_out <= hue_in;
		end
	end

endmodule

>>> bench/tb.sv
// tb: self-checking bench for wheel_point_to_hue_saturation
// predicts hue and saturation with its own vectoring cordic and compares each result item
// depends on whps_pkg and the rtl top level
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STAGES = 16;
	localparam int CB     = 14;
	localparam int LATENCY = STAGES + 12;
	localparam int LIMIT  = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [12:0] cfg_data = '0;

	typedef struct packed {
		logic [8:0] hue;
		logic [7:0] sat;
	} hs_t;

	hs_t hs_expected [$];
	logic [12:0] ref_cx = whps_pkg::CENTER_RESET;
	logic [12:0] ref_cy = whps_pkg::CENTER_RESET;
	logic [11:0] ref_rad = whps_pkg::RADIUS_RESET;
	int mismatches = 0;
	int cycles = 0;
	int hold_off = 0;
	bit stall_on = 1'b1;
	bit long_hold = 1'b0;

	wheel_point_to_hue_saturation #(.CORDIC_STAGES(STAGES), .COORD_BITS(CB)) u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("** wheel_point_to_hue_saturation: FAILED **");
			$finish;
		end
	end

	function automatic hs_t predict_hs(logic signed [13:0] px, logic signed [13:0] py);
		longint dx, dy, x, y, xs, ys, mag, rad, sat;
		logic [15:0] z;
		hs_t r;
		dx = longint'(px) - longint'(ref_cx);
		dy = longint'(ref_cy) - longint'(py);
		z = '0;
		if (dx == 0 && dy == 0) return '0;
		x = dy * 256;
		y = dx * 256;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = whps_pkg::HALF_TURN;
		end
		for (int i = 0; i < STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + whps_pkg::ATAN_TURNS[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - whps_pkg::ATAN_TURNS[i];
			end
		end
		r.hue = 9'((longint'(z) * 360) >> 16);
		mag = (x * 39797) >> 16;
		rad = (ref_rad == 0) ? 1 : longint'(ref_rad);
		sat = (mag * 255) / (rad * 256);
		r.sat = (sat > 255) ? 8'd255 : 8'(sat);
		return r;
	endfunction

	// receiver: random stalls plus a counted long hold-off
	always @(posedge clk) begin
		if (long_hold) begin
			long_hold = 1'b0;
			hold_off <= 300;
			m_tready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 1'b0;
		end else if (!stall_on) begin
			m_tready <= 1'b1;
		end else if ($urandom_range(0, 99) < 5) begin
			hold_off <= $urandom_range(10, 60);
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		hs_t got, want;
		if (m_tvalid && m_tready) begin
			got.hue = m_tdata[8:0];
			got.sat = m_tdata[16:9];
			if (hs_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected item hue=%0d sat=%0d", got.hue, got.sat);
			end else begin
				want = hs_expected.pop_front();
				if (got !== want || m_tdata[23:17] !== '0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected hue=%0d sat=%0d, got hue=%0d sat=%0d",
							want.hue, want.sat, got.hue, got.sat);
				end
			end
		end
	end

	task automatic send_point(logic [13:0] px, logic [13:0] py, bit gaps);
		int g;
		g = 0;
		if (gaps) begin
			g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
			if ($urandom_range(0, 3) == 0) g = 0;
		end
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, py, px};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		hs_expected.push_back(predict_hs(px, py));
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (hs_expected.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(whps_pkg::reg_idx_t idx, logic [12:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			whps_pkg::REG_CENTER_X: ref_cx = val;
			whps_pkg::REG_CENTER_Y: ref_cy = val;
			whps_pkg::REG_RADIUS:   ref_rad = val[11:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_wheel(logic [12:0] cx, logic [12:0] cy, logic [11:0] rad);
		drain_results();
		write_reg(whps_pkg::REG_CENTER_X, cx);
		write_reg(whps_pkg::REG_CENTER_Y, cy);
		write_reg(whps_pkg::REG_RADIUS, {1'b0, rad});
	endtask

	task automatic test_directed();
		logic [13:0] pts [][2];
		pts = '{'{14'd75, 14'd75}, '{14'd75, 14'd0}, '{14'd150, 14'd75}, '{14'd75, 14'd150},
			'{14'd0, 14'd75}, '{14'd76, 14'd0}, '{14'd74, 14'd0}, '{14'd74, 14'd75},
			'{14'h1FFF, 14'h1FFF}, '{14'h2000, 14'h2000}, '{14'h1FFF, 14'h2000},
			'{14'h2000, 14'h1FFF}, '{14'd0, 14'd0}, '{14'h3FFF, 14'h3FFF},
			'{14'd128, 14'd22}, '{14'd75, 14'd76}, '{14'd100, 14'd100}, '{14'd50, 14'd25}};
		foreach (pts[i]) send_point(pts[i][0], pts[i][1], 1'b0);
		set_wheel(13'd0, 13'd0, 12'd0);
		send_point(14'd0, 14'd0, 1'b0);
		send_point(14'd1, 14'd0, 1'b0);
		send_point(14'h3FFF, 14'h3FFF, 1'b0);
		set_wheel(13'h1FFF, 13'h1FFF, 12'hFFF);
		send_point(14'h2000, 14'h2000, 1'b0);
		send_point(14'h1FFF, 14'h1FFF, 1'b0);
		send_point(14'h2000, 14'h1FFF, 1'b0);
	endtask

	task automatic test_random(int n, bit near);
		logic [13:0] px, py;
		int r;
		for (int k = 0; k < n; k++) begin
			r = ref_rad + 2;
			if (near && $urandom_range(0, 3) != 0) begin
				px = 14'(int'(ref_cx) + $urandom_range(0, 2 * r) - r);
				py = 14'(int'(ref_cy) + $urandom_range(0, 2 * r) - r);
			end else begin
				px = 14'($urandom);
				py = 14'($urandom);
			end
			send_point(px, py, 1'b1);
		end
	endtask

	task automatic test_backpressure();
		drain_results();
		long_hold = 1'b1;
		test_random(120, 1'b1);
		drain_results();
		stall_on = 1'b0;
		for (int k = 0; k < 100; k++) send_point(14'($urandom), 14'($urandom), 1'b0);
		stall_on = 1'b1;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		set_wheel(13'd75, 13'd75, 12'd75);
		test_random(500, 1'b1);
		set_wheel(13'd4000, 13'd100, 12'd1);
		test_random(200, 1'b1);
		set_wheel(13'($urandom), 13'($urandom), 12'($urandom_range(1, 4095)));
		test_random(300, 1'b1);
		set_wheel(13'd300, 13'd8000, 12'd2000);
		test_random(300, 1'b0);
		test_backpressure();
		drain_results();
		if (mismatches == 0) begin
			$display("** wheel_point_to_hue_saturation: PASSED **");
		end else begin
			$display("** wheel_point_to_hue_saturation: FAILED **");
		end
		$finish;
	end
endmodule
